[rtl/n64_pad_poll_and_rumble_control_assert.svh]
// assertion macros for the pad poll and rumble control rtl
`ifndef N64_PAD_POLL_AND_RUMBLE_CONTROL_ASSERT_SVH
`define N64_PAD_POLL_AND_RUMBLE_CONTROL_ASSERT_SVH

// checked only while out of reset
`define N64PR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define N64PR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/n64pr_pkg.sv]
// shared types and codes for the pad poll and rumble control block
package n64pr_pkg;

    typedef enum logic [1:0] {
        OP_POLL    = 2'd0,
        OP_VIBRATE = 2'd1,
        OP_TAKEN   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        WR_NONE      = 2'd0,
        WR_INIT      = 2'd1,
        WR_MOTOR_ON  = 2'd2,
        WR_MOTOR_OFF = 2'd3
    } t_wr;

    typedef enum logic [2:0] {
        PH_INIT    = 3'd0,
        PH_OFF     = 3'd1,
        PH_TURNON  = 3'd2,
        PH_ON      = 3'd3,
        PH_TURNOFF = 3'd4,
        PH_UNAVAIL = 3'd5
    } t_phase;

    localparam logic [7:0] AXIS_OFFSET = 8'h7f;

    // report bytes that vary; byte 0 and the 0x7f filler follow from valid
    typedef struct packed {
        logic       valid;
        logic [7:0] axis_x;
        logic [7:0] axis_y;
        logic [7:0] btn_main;
        logic [5:0] btn_extra;
    } t_report;

    typedef struct packed {
        t_phase  phase;
        t_report built;
        t_report sent;
    } t_state;

    typedef struct packed {
        logic       poll_failed;
        t_wr        write_issued;
        logic [7:0] axis_x;
        logic [7:0] axis_y;
        logic [7:0] buttons_main;
        logic [5:0] buttons_extra;
        logic       report_changed;
        t_phase     pack_state;
    } t_result;

endpackage

[rtl/n64pr_event.sv]
// next-state and result logic for one poll, vibration or report-taken request
module n64pr_event (
    input  logic [1:0]        i_operation,
    input  logic              i_caps_ok,
    input  logic [7:0]        i_caps_flags,
    input  logic              i_write_acked,
    input  logic              i_status_ok,
    input  logic [7:0]        i_buttons_first,
    input  logic [7:0]        i_buttons_second,
    input  logic signed [7:0] i_stick_x,
    input  logic signed [7:0] i_stick_y,
    input  logic              i_vibrate,
    input  n64pr_pkg::t_state  i_state,
    output n64pr_pkg::t_state  o_state,
    output n64pr_pkg::t_result o_result
);
    import n64pr_pkg::*;

    t_op     op;
    t_phase  pre_phase;
    t_report fresh;
    logic    failed;
    t_wr     wr;

    assign op = t_op'(i_operation);

    always_comb begin
        fresh.valid        = 1'b1;
        fresh.axis_x       = 8'(i_stick_x) + AXIS_OFFSET;
        fresh.axis_y       = AXIS_OFFSET - 8'(i_stick_y);
        fresh.btn_main     = {i_buttons_second[0], i_buttons_second[1],
                              i_buttons_second[2], i_buttons_second[3],
                              i_buttons_first[4], i_buttons_first[5],
                              i_buttons_first[6], i_buttons_first[7]};
        fresh.btn_extra    = {i_buttons_first[0], i_buttons_first[1],
                              i_buttons_first[2], i_buttons_first[3],
                              i_buttons_second[4], i_buttons_second[5]};
    end

    // pack presence check before the write step
    always_comb begin
        pre_phase = i_state.phase;
        if (!i_caps_flags[0]) begin
            pre_phase = PH_UNAVAIL;
        end else if (i_state.phase == PH_UNAVAIL) begin
            pre_phase = PH_INIT;
        end
    end

    always_comb begin
        o_state = i_state;
        failed  = 1'b0;
        wr      = WR_NONE;
        unique case (op)
            OP_POLL: begin
                if (!i_caps_ok) begin
                    o_state.phase = PH_INIT;
                    failed        = 1'b1;
                end else begin
                    o_state.phase = pre_phase;
                    unique case (pre_phase)
                        PH_INIT: begin
                            wr = WR_INIT;
                            if (i_write_acked) o_state.phase = PH_TURNOFF;
                        end
                        PH_TURNON: begin
                            wr = WR_MOTOR_ON;
                            if (i_write_acked) o_state.phase = PH_ON;
                        end
                        PH_TURNOFF: begin
                            wr = WR_MOTOR_OFF;
                            if (i_write_acked) o_state.phase = PH_OFF;
                        end
                        default: begin
                            wr = WR_NONE;
                        end
                    endcase
                    if (!i_status_ok) begin
                        failed = 1'b1;
                    end else begin
                        o_state.built = fresh;
                    end
                end
            end
            OP_VIBRATE: begin
                if (i_state.phase != PH_UNAVAIL && i_state.phase != PH_INIT) begin
                    if (i_vibrate) begin
                        if (i_state.phase != PH_ON) o_state.phase = PH_TURNON;
                    end else begin
                        if (i_state.phase != PH_OFF) o_state.phase = PH_TURNOFF;
                    end
                end
            end
            OP_TAKEN: begin
                o_state.sent = i_state.built;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    always_comb begin
        o_result.poll_failed    = failed;
        o_result.write_issued   = wr;
        o_result.axis_x         = o_state.built.axis_x;
        o_result.axis_y         = o_state.built.axis_y;
        o_result.buttons_main   = o_state.built.btn_main;
        o_result.buttons_extra  = o_state.built.btn_extra;
        o_result.report_changed = (o_state.built != o_state.sent);
        o_result.pack_state     = o_state.phase;
    end

endmodule

[rtl/n64_pad_poll_and_rumble_control.sv]
// top level: pad poll and rumble-pack control with registered result and skid stage
//
//  channel  direction  handshake                  payload
//  in       to block   i_in_valid / o_in_ready    i_operation .. i_vibrate
//  out      from block o_out_valid / i_out_ready  o_poll_failed .. o_pack_state
//
// one request per cycle while o_in_ready is high; each result is registered
// state (rumble phase, built and sent reports) updates at the accepting edge
// a two-entry result buffer lets one more request in while the output stalls
// o_in_ready drops only when both result entries are full
// synchronous active-low reset clears state to pack unavailable, reports zero
`include "n64_pad_poll_and_rumble_control_assert.svh"

module n64_pad_poll_and_rumble_control (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_operation,
    input  logic              i_caps_ok,
    input  logic [7:0]        i_caps_flags,
    input  logic              i_write_acked,
    input  logic              i_status_ok,
    input  logic [7:0]        i_buttons_first,
    input  logic [7:0]        i_buttons_second,
    input  logic signed [7:0] i_stick_x,
    input  logic signed [7:0] i_stick_y,
    input  logic              i_vibrate,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_poll_failed,
    output logic [1:0]        o_write_issued,
    output logic [7:0]        o_axis_x,
    output logic [7:0]        o_axis_y,
    output logic [7:0]        o_buttons_main,
    output logic [5:0]        o_buttons_extra,
    output logic              o_report_changed,
    output logic [2:0]        o_pack_state
);
    import n64pr_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_main;
    t_result r_skid;
    logic    r_main_valid;
    logic    r_skid_valid;
    logic    in_acc;
    logic    out_acc;

    assign o_in_ready = !r_skid_valid;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_main_valid && i_out_ready;

    n64pr_event u_event (
        .i_operation      (i_operation),
        .i_caps_ok        (i_caps_ok),
        .i_caps_flags     (i_caps_flags),
        .i_write_acked    (i_write_acked),
        .i_status_ok      (i_status_ok),
        .i_buttons_first  (i_buttons_first),
        .i_buttons_second (i_buttons_second),
        .i_stick_x        (i_stick_x),
        .i_stick_y        (i_stick_y),
        .i_vibrate        (i_vibrate),
        .i_state          (r_state),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= PH_UNAVAIL;
            r_state.built <= '0;
            r_state.sent  <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // result buffer: main entry drives the port, skid catches a stalled request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_acc) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main_valid <= in_acc;
                end
            end else if (in_acc) begin
                if (!r_main_valid) begin
                    r_main_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc && r_skid_valid) begin
            r_main <= r_skid;
        end else if (in_acc && (out_acc || !r_main_valid)) begin
            r_main <= n_result;
        end
        if (in_acc && r_main_valid && !out_acc) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid      = r_main_valid;
    assign o_poll_failed    = r_main.poll_failed;
    assign o_write_issued   = r_main.write_issued;
    assign o_axis_x         = r_main.axis_x;
    assign o_axis_y         = r_main.axis_y;
    assign o_buttons_main   = r_main.buttons_main;
    assign o_buttons_extra  = r_main.buttons_extra;
    assign o_report_changed = r_main.report_changed;
    assign o_pack_state     = r_main.pack_state;

    `N64PR_ASSERT(a_skid_needs_main, r_skid_valid |-> r_main_valid, "skid full with main empty")
    `N64PR_ASSERT(a_sent_after_built, r_state.sent.valid |-> r_state.built.valid, "sent report without built report")
    `N64PR_ASSERT(a_caps_fail_init, (in_acc && i_operation == OP_POLL && !i_caps_ok) |=> (r_state.phase == PH_INIT), "capability failure did not reset pack to init")
    `N64PR_ASSERT(a_state_holds, !in_acc |=> $stable(r_state), "state moved without a request")
    `N64PR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_main_valid && !r_skid_valid), "result buffer not empty after reset")

endmodule

[test/n64_pad_poll_and_rumble_control_test.sv]
// testbench for the pad poll and rumble control block: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module n64_pad_poll_and_rumble_control_test;
    import n64pr_pkg::*;

    typedef struct {
        t_op               op;
        logic              caps_ok;
        logic [7:0]        caps_flags;
        logic              write_acked;
        logic              status_ok;
        logic [7:0]        buttons_first;
        logic [7:0]        buttons_second;
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
        logic              vibrate;
        int unsigned       gap_after;
        bit                drain_first;
    } pad_req;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_operation = '0;
    logic              i_caps_ok = 1'b0;
    logic [7:0]        i_caps_flags = '0;
    logic              i_write_acked = 1'b0;
    logic              i_status_ok = 1'b0;
    logic [7:0]        i_buttons_first = '0;
    logic [7:0]        i_buttons_second = '0;
    logic signed [7:0] i_stick_x = '0;
    logic signed [7:0] i_stick_y = '0;
    logic              i_vibrate = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_poll_failed;
    logic [1:0]        o_write_issued;
    logic [7:0]        o_axis_x;
    logic [7:0]        o_axis_y;
    logic [7:0]        o_buttons_main;
    logic [5:0]        o_buttons_extra;
    logic              o_report_changed;
    logic [2:0]        o_pack_state;

    pad_req      pending_reqs[$];
    t_result     expected_results[$];
    pad_req      live_req;
    int unsigned n_offered = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_errors = 0;
    int unsigned total_reqs = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_seen = 0;
    int unsigned rx_stall = 0;
    bit          tx_calm = 1'b0;
    bit          hold_off = 1'b0;
    int unsigned op_seen[4] = '{0, 0, 0, 0};
    int unsigned wr_seen[4] = '{0, 0, 0, 0};
    int unsigned n_changed = 0;

    // predicted block state
    t_phase          phase_q = PH_UNAVAIL;
    logic [8:0][7:0] built_q = '0;
    logic [8:0][7:0] sent_q = '0;

    n64_pad_poll_and_rumble_control dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic pad_req mk_req(t_op op, logic caps_ok, logic [7:0] flags, logic acked,
                                      logic st_ok, logic [7:0] b1, logic [7:0] b2,
                                      logic signed [7:0] x, logic signed [7:0] y, logic vib);
        pad_req r;
        r.op = op;
        r.caps_ok = caps_ok;
        r.caps_flags = flags;
        r.write_acked = acked;
        r.status_ok = st_ok;
        r.buttons_first = b1;
        r.buttons_second = b2;
        r.stick_x = x;
        r.stick_y = y;
        r.vibrate = vib;
        r.gap_after = 0;
        r.drain_first = 1'b0;
        return r;
    endfunction

    task automatic queue_req(pad_req r, bit drain);
        r.gap_after = tx_calm ? 0 : $urandom_range(0, 4);
        r.drain_first = drain;
        pending_reqs.push_back(r);
    endtask

    function automatic t_result predict_pad(pad_req r);
        t_result res;
        logic [7:0] main_btn;
        logic [7:0] extra_btn;
        res = '0;
        case (r.op)
            OP_POLL: begin
                if (!r.caps_ok) begin
                    phase_q = PH_INIT;
                    res.poll_failed = 1'b1;
                end else begin
                    if (r.caps_flags[0] && phase_q == PH_UNAVAIL) phase_q = PH_INIT;
                    if (!r.caps_flags[0]) phase_q = PH_UNAVAIL;
                    case (phase_q)
                        PH_INIT: begin
                            res.write_issued = WR_INIT;
                            if (r.write_acked) phase_q = PH_TURNOFF;
                        end
                        PH_TURNON: begin
                            res.write_issued = WR_MOTOR_ON;
                            if (r.write_acked) phase_q = PH_ON;
                        end
                        PH_TURNOFF: begin
                            res.write_issued = WR_MOTOR_OFF;
                            if (r.write_acked) phase_q = PH_OFF;
                        end
                        default: ;
                    endcase
                    if (!r.status_ok) begin
                        res.poll_failed = 1'b1;
                    end else begin
                        main_btn = {r.buttons_second[0], r.buttons_second[1],
                                    r.buttons_second[2], r.buttons_second[3],
                                    r.buttons_first[4], r.buttons_first[5],
                                    r.buttons_first[6], r.buttons_first[7]};
                        extra_btn = {2'b00, r.buttons_first[0], r.buttons_first[1],
                                     r.buttons_first[2], r.buttons_first[3],
                                     r.buttons_second[4], r.buttons_second[5]};
                        built_q[0] = 8'h01;
                        built_q[1] = 8'(r.stick_x) + AXIS_OFFSET;
                        built_q[2] = AXIS_OFFSET - 8'(r.stick_y);
                        built_q[3] = 8'h7f;
                        built_q[4] = 8'h7f;
                        built_q[5] = 8'h7f;
                        built_q[6] = 8'h7f;
                        built_q[7] = main_btn;
                        built_q[8] = extra_btn;
                    end
                end
            end
            OP_VIBRATE: begin
                if (phase_q != PH_UNAVAIL && phase_q != PH_INIT) begin
                    if (r.vibrate) begin
                        if (phase_q != PH_ON) phase_q = PH_TURNON;
                    end else begin
                        if (phase_q != PH_OFF) phase_q = PH_TURNOFF;
                    end
                end
            end
            OP_TAKEN: sent_q = built_q;
            default: ;
        endcase
        res.axis_x = built_q[1];
        res.axis_y = built_q[2];
        res.buttons_main = built_q[7];
        res.buttons_extra = built_q[8][5:0];
        res.report_changed = (built_q != sent_q);
        res.pack_state = phase_q;
        return res;
    endfunction

    function automatic string fmt_result(t_result r);
        return $sformatf(
            "fail=%0d wr=%0d x=%02h y=%02h main=%02h extra=%02h chg=%0d phase=%0d",
            r.poll_failed, r.write_issued, r.axis_x, r.axis_y, r.buttons_main,
            r.buttons_extra, r.report_changed, r.pack_state);
    endfunction

    // request driver
    always @(negedge i_clk) begin
        pad_req cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && n_accepted != n_offered)) begin
            if (tx_gap != 0) begin
                i_in_valid <= 1'b0;
                tx_gap--;
            end else if (pending_reqs.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (pending_reqs[0].drain_first && expected_results.size() != 0) begin
                i_in_valid <= 1'b0;
            end else begin
                cur = pending_reqs.pop_front();
                live_req = cur;
                i_operation <= cur.op;
                i_caps_ok <= cur.caps_ok;
                i_caps_flags <= cur.caps_flags;
                i_write_acked <= cur.write_acked;
                i_status_ok <= cur.status_ok;
                i_buttons_first <= cur.buttons_first;
                i_buttons_second <= cur.buttons_second;
                i_stick_x <= cur.stick_x;
                i_stick_y <= cur.stick_y;
                i_vibrate <= cur.vibrate;
                i_in_valid <= 1'b1;
                n_offered++;
                tx_gap = cur.gap_after;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (n_results != rx_seen) begin
                rx_seen = n_results;
                rx_stall = ((n_results / 80) % 3 == 2) ? 0 : $urandom_range(0, 4);
            end
            if (hold_off || rx_stall != 0) begin
                i_out_ready <= 1'b0;
                if (!hold_off) rx_stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // long receiver hold-offs so the result buffer fills and input stalls
    initial begin
        while (n_accepted < 120) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (60) @(posedge i_clk);
        hold_off = 1'b0;
        while (n_accepted < 450) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (45) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // monitor: check results, then predict accepted requests
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen.poll_failed = o_poll_failed;
                seen.write_issued = t_wr'(o_write_issued);
                seen.axis_x = o_axis_x;
                seen.axis_y = o_axis_y;
                seen.buttons_main = o_buttons_main;
                seen.buttons_extra = o_buttons_extra;
                seen.report_changed = o_report_changed;
                seen.pack_state = t_phase'(o_pack_state);
                n_results++;
                if (expected_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result: %s", fmt_result(seen));
                end else begin
                    want = expected_results.pop_front();
                    if (seen !== want) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("mismatch on result %0d", n_results);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(seen));
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = predict_pad(live_req);
                expected_results.push_back(want);
                op_seen[live_req.op]++;
                wr_seen[want.write_issued]++;
                if (want.report_changed) n_changed++;
                n_accepted++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        pad_req r;
        int unsigned sel;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] sx;
        logic [7:0] sy;

        // directed walk through the pack sequence and report extremes
        queue_req(mk_req(OP_NONE, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 0), 0);
        queue_req(mk_req(OP_TAKEN, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 0), 0);
        queue_req(mk_req(OP_VIBRATE, 1, 8'hff, 1, 1, 8'hff, 8'hff, -1, -1, 1), 0);
        queue_req(mk_req(OP_POLL, 0, 8'hff, 1, 1, 8'hff, 8'hff, 127, 127, 1), 0);
        queue_req(mk_req(OP_VIBRATE, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 1), 0);
        queue_req(mk_req(OP_POLL, 1, 8'h01, 0, 1, 8'hff, 8'hff, 127, -128, 0), 0);
        queue_req(mk_req(OP_POLL, 1, 8'hff, 1, 1, 8'h00, 8'h00, -128, 127, 0), 0);
        queue_req(mk_req(OP_POLL, 1, 8'h01, 1, 0, 8'h12, 8'h34, 5, 6, 0), 0);
        queue_req(mk_req(OP_VIBRATE, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 0), 0);
        queue_req(mk_req(OP_VIBRATE, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 1), 0);
        queue_req(mk_req(OP_POLL, 1, 8'h01, 0, 1, 8'ha5, 8'h5a, 0, 0, 0), 0);
        queue_req(mk_req(OP_POLL, 1, 8'h01, 1, 1, 8'ha5, 8'h5a, 0, 0, 0), 0);
        queue_req(mk_req(OP_VIBRATE, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 1), 0);
        queue_req(mk_req(OP_TAKEN, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 0), 0);
        queue_req(mk_req(OP_POLL, 1, 8'h01, 1, 1, 8'ha5, 8'h5a, 0, 0, 0), 0);
        queue_req(mk_req(OP_POLL, 1, 8'h81, 1, 1, 8'h5a, 8'ha5, -1, -1, 0), 0);
        queue_req(mk_req(OP_VIBRATE, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 0), 0);
        queue_req(mk_req(OP_VIBRATE, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 1), 0);
        queue_req(mk_req(OP_POLL, 1, 8'hfe, 1, 1, 8'h0f, 8'hf0, 1, 1, 0), 0);
        queue_req(mk_req(OP_VIBRATE, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 0), 0);
        queue_req(mk_req(OP_POLL, 1, 8'h01, 1, 1, 8'hf0, 8'h0f, 1, 1, 0), 0);
        queue_req(mk_req(OP_POLL, 0, 8'h01, 1, 1, 8'h00, 8'h00, 0, 0, 0), 0);
        queue_req(mk_req(OP_NONE, 1, 8'hff, 1, 1, 8'hff, 8'hff, -128, -128, 1), 0);
        queue_req(mk_req(OP_TAKEN, 0, 8'h00, 0, 0, 8'h00, 8'h00, 0, 0, 0), 0);

        // random traffic, mostly well-formed polls with pack present
        b1 = 8'h00;
        b2 = 8'h00;
        sx = 8'h00;
        sy = 8'h00;
        for (int k = 0; k < 700; k++) begin
            tx_calm = ((k / 60) % 3 == 1);
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 9) >= 4) begin
                b1 = 8'($urandom);
                b2 = 8'($urandom);
                sx = 8'($urandom);
                sy = 8'($urandom);
            end
            r = mk_req(OP_POLL, 1, 8'($urandom) | 8'h01, $urandom_range(0, 3) != 0,
                       $urandom_range(0, 7) != 0, b1, b2, sx, sy, 1'($urandom_range(0, 1)));
            if (sel >= 55 && sel < 75) r.op = OP_VIBRATE;
            else if (sel >= 75 && sel < 87) r.op = OP_TAKEN;
            else if (sel >= 87 && sel < 93) r.caps_ok = 1'b0;
            else if (sel >= 93 && sel < 97) r.caps_flags[0] = 1'b0;
            else if (sel >= 97) r.op = OP_NONE;
            queue_req(r, (k % 150) == 0);
        end
        total_reqs = pending_reqs.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != total_reqs) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d requests: %0d polls, %0d vibration, %0d report taken, %0d unused op",
                 n_accepted, op_seen[OP_POLL], op_seen[OP_VIBRATE], op_seen[OP_TAKEN],
                 op_seen[OP_NONE]);
        $display("pack writes init/on/off %0d/%0d/%0d, %0d results with report changed",
                 wr_seen[WR_INIT], wr_seen[WR_MOTOR_ON], wr_seen[WR_MOTOR_OFF], n_changed);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[n64_pad_poll_and_rumble_control.f]
+incdir+rtl
rtl/n64pr_pkg.sv
rtl/n64pr_event.sv
rtl/n64_pad_poll_and_rumble_control.sv
test/n64_pad_poll_and_rumble_control_test.sv
